/* src/xor_checksum_frame_parser_core_defines.svh */
// Assertion macros for the checksum frame parser.
// Included by the top level; no other dependencies.
`ifndef XOR_CHECKSUM_FRAME_PARSER_CORE_DEFINES_SVH
`define XOR_CHECKSUM_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XCFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xcfp check failed");

// Next-cycle implication, disabled during reset.
`define XCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xcfp check failed");

`endif

/* src/xcfp_pkg.sv */
// Constants, types and lookup functions for the checksum frame parser.
// Self-contained; used by xor_checksum_frame_parser_core.
package xcfp_pkg;

	localparam int MAX_FRAME = 32;
	localparam int PosW = $clog2(MAX_FRAME + 1);
	localparam int OffW = 5;
	localparam int ID_COUNT = 12;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [OffW-1:0] OFF_MAX = 5'd31;
	localparam logic [OffW-1:0] XOR_FIRST = 5'd1;
	localparam logic [OffW-1:0] XOR_LAST = 5'd6;
	localparam logic [OffW-1:0] CAP_FIRST = 5'd3;
	localparam logic [OffW-1:0] CAP_LAST = 5'd6;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_BAD_FORMAT = 2'd1,
		ST_BAD_ID = 2'd2,
		ST_BAD_CHECKSUM = 2'd3
	} status_t;

	function automatic logic [7:0] hex_upper(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'd0, nib};
		return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
	endfunction

	function automatic logic [15:0] expected_id(input logic [3:0] idx);
		logic [15:0] id;
		case (idx)
			4'd0: id = {8'h49, 8'h65};
			4'd1: id = {8'h57, 8'h6E};
			4'd2: id = {8'h6F, 8'h59};
			4'd3: id = {8'h75, 8'h6F};
			4'd4: id = {8'h6C, 8'h75};
			4'd5: id = {8'h64, 8'h72};
			4'd6: id = {8'h48, 8'h44};
			4'd7: id = {8'h61, 8'h61};
			4'd8: id = {8'h76, 8'h64};
			4'd9: id = {8'h65, 8'h64};
			4'd10: id = {8'h42, 8'h79};
			4'd11: id = {8'h65, 8'h2E};
			default: id = 16'h0000;
		endcase
		return id;
	endfunction

endpackage

/* src/xor_checksum_frame_parser_core.sv */
// Checksum frame parser: one received byte per transfer in, one verdict per frame out.
// Depends on xcfp_pkg and xor_checksum_frame_parser_core_defines.svh.
//
// Input channel (in_valid/in_stall): rx_byte, frame_end, id_slot. Each transfer
// carries one frame byte; frame_end marks the last byte of the frame.
// Output channel (out_valid/out_stall): frame_status, calib_byte,
// track_byte. One transfer per frame, issued for the byte with frame_end.
// A '$' opens the frame, the six bytes after it are XORed and compared with
// the two hex characters after the first '*'; the ID at offsets 3 and 4 is
// compared with the table entry selected by id_slot.
// The last byte passes through the input register, then the update and verdict logic
// into the result register, from which the verdict is offered on the output channel.
// Throughput: one byte per cycle while in_stall is low, one state update per byte.
// When out_stall holds a pending verdict, bytes without frame_end keep flowing;
// a byte with frame_end waits in the input register until the result register
// frees, and in_stall rises behind it.
// Reset clears all frame state and both valid flags; no warm-up is needed.
`include "xor_checksum_frame_parser_core_defines.svh"

module xor_checksum_frame_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	input  logic [3:0] id_slot,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] frame_status,
	output logic [7:0] calib_byte,
	output logic [7:0] track_byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic [3:0] idx_s1;

	logic                          start_q, start_n;
	logic                          star_q, star_n;
	logic [xcfp_pkg::OffW-1:0]     off_q, off_n;
	logic [xcfp_pkg::PosW-1:0]     pos_q, pos_n;
	logic [7:0]                    xor_q, xor_n;
	logic [3:0][7:0]               cap_q, cap_n;
	logic [1:0][7:0]               chk_q, chk_n;
	logic [1:0]                    cnt_q, cnt_n;
	logic [xcfp_pkg::OffW-1:0]     cap_off;

	logic                          out_valid_q;
	xcfp_pkg::status_t             status_q, status_n;
	logic [7:0]                    calib_q, calib_n;
	logic [7:0]                    track_q, track_n;

	logic out_free;
	logic proc_go;
	logic in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign proc_go = valid_s1 && (!end_s1 || out_free);
	assign in_stall = valid_s1 && !proc_go;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (proc_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
			end_s1 <= frame_end;
			idx_s1 <= id_slot;
		end
	end

	always_comb begin
		start_n = start_q;
		star_n = star_q;
		off_n = off_q;
		pos_n = pos_q;
		xor_n = xor_q;
		cap_n = cap_q;
		chk_n = chk_q;
		cnt_n = cnt_q;
		cap_off = '0;
		if (pos_q < xcfp_pkg::PosW'(xcfp_pkg::MAX_FRAME)) begin
			pos_n = pos_q + xcfp_pkg::PosW'(1);
			if (byte_s1 == xcfp_pkg::CH_START && !star_q) begin
				start_n = 1'b1;
				off_n = '0;
				xor_n = '0;
				cap_n = '0;
			end else if (start_q) begin
				if (off_q != xcfp_pkg::OFF_MAX) begin
					off_n = off_q + 5'd1;
				end
				if (off_n >= xcfp_pkg::XOR_FIRST && off_n <= xcfp_pkg::XOR_LAST) begin
					xor_n = xor_q ^ byte_s1;
				end
				if (off_n >= xcfp_pkg::CAP_FIRST && off_n <= xcfp_pkg::CAP_LAST) begin
					cap_off = off_n - xcfp_pkg::CAP_FIRST;
					cap_n[cap_off[1:0]] = byte_s1;
				end
				if (star_q) begin
					if (cnt_q < 2'd2) begin
						chk_n[cnt_q[0]] = byte_s1;
						cnt_n = cnt_q + 2'd1;
					end
				end else if (byte_s1 == xcfp_pkg::CH_STAR) begin
					star_n = 1'b1;
				end
			end
		end
	end

	always_comb begin
		calib_n = '0;
		track_n = '0;
		if (!start_n || !star_n) begin
			status_n = xcfp_pkg::ST_BAD_FORMAT;
		end else if (xcfp_pkg::hex_upper(xor_n[7:4]) != chk_n[0] ||
				xcfp_pkg::hex_upper(xor_n[3:0]) != chk_n[1]) begin
			status_n = xcfp_pkg::ST_BAD_CHECKSUM;
		end else if (idx_s1 >= 4'(xcfp_pkg::ID_COUNT) ||
				{cap_n[0], cap_n[1]} != xcfp_pkg::expected_id(idx_s1)) begin
			status_n = xcfp_pkg::ST_BAD_ID;
		end else begin
			status_n = xcfp_pkg::ST_GOOD;
			calib_n = cap_n[2];
			track_n = cap_n[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			star_q <= 1'b0;
			off_q <= '0;
			pos_q <= '0;
			xor_q <= '0;
			cap_q <= '0;
			chk_q <= '0;
			cnt_q <= '0;
		end else if (proc_go) begin
			if (end_s1) begin
				start_q <= 1'b0;
				star_q <= 1'b0;
				off_q <= '0;
				pos_q <= '0;
				xor_q <= '0;
				cap_q <= '0;
				chk_q <= '0;
				cnt_q <= '0;
			end else begin
				start_q <= start_n;
				star_q <= star_n;
				off_q <= off_n;
				pos_q <= pos_n;
				xor_q <= xor_n;
				cap_q <= cap_n;
				chk_q <= chk_n;
				cnt_q <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_go && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go && end_s1) begin
			status_q <= status_n;
			calib_q <= calib_n;
			track_q <= track_n;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = status_q;
	assign calib_byte = calib_q;
	assign track_byte = track_q;

	`XCFP_ASSERT_NOW(a_status_zero_unless_good, clk, arst_n,
		out_valid_q && status_q != xcfp_pkg::ST_GOOD, calib_q == 8'd0 && track_q == 8'd0)
	`XCFP_ASSERT_NEXT(a_end_gives_result, clk, arst_n, proc_go && end_s1, out_valid_q)
	`XCFP_ASSERT_NEXT(a_end_clears_frame, clk, arst_n, proc_go && end_s1,
		!start_q && !star_q && pos_q == '0 && cnt_q == 2'd0)
	`XCFP_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall,
		valid_s1 && end_s1 && out_valid_q && out_stall)

endmodule
